### hdl/keyed_entry_table_macros.svh
// ----------------------------------------------------------------------------
// keyed_entry_table assertion macros
// Shared concurrent assertion forms for the keyed entry table RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_MACROS_SVH
`define KEYED_ENTRY_TABLE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define KET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every rising clock edge outside reset.
`define KET_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

### hdl/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg
// Constants, codes and controller/datapath interface types for the
// keyed entry table.
// ----------------------------------------------------------------------------
package ket_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int LIMIT_W     = 7;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int COUNT_W     = 7;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int OP_W        = 3;
    localparam int STS_W       = 3;
    localparam int LIMIT_RESET = 64;

    typedef logic [CMP_W-1:0] t_cmp;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_DEL = 3'd1,
        OP_UPD = 3'd2,
        OP_GET = 3'd3,
        OP_CLR = 3'd4
    } t_opcode;

    typedef enum logic [STS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_SAME    = 3'd4
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    scan;
        logic    shift_init;
        logic    shift;
        logic    clr_fill;
        logic    append;
        logic    update;
        logic    dec_fill;
        logic    fetch;
        logic    result;
        logic    give_found;
        t_status status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    hit_k;
        logic    hit_nk;
        logic    same_key;
        logic    walk_done;
        logic    out_free;
    } t_sts;

endpackage

### hdl/ket_ctrl.sv
// ----------------------------------------------------------------------------
// ket_ctrl
// Request sequencer: decode, key scan, decision, compaction and result.
// ----------------------------------------------------------------------------
module ket_ctrl
    import ket_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_give_found, n_give_found;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_give_found = r_give_found;
        o_cmd        = '0;
        o_cmd.status     = r_status;
        o_cmd.give_found = r_give_found;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load   = 1'b1;
                    n_give_found = 1'b0;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_ADD: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    OP_DEL, OP_UPD, OP_GET: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    OP_CLR: begin
                        o_cmd.clr_fill = 1'b1;
                        n_status       = ST_OK;
                        n_state        = S_RESULT;
                    end
                    default: begin
                        n_status = ST_OK;
                        n_state  = S_RESULT;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state  = S_RESULT;
                n_status = ST_OK;
                case (i_sts.op)
                    OP_ADD: begin
                        if (i_sts.hit_k) begin
                            n_status = ST_DUP;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    OP_DEL: begin
                        if (!i_sts.hit_k) begin
                            n_status = ST_MISSING;
                        end else begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end
                    end
                    OP_UPD: begin
                        if (!i_sts.hit_k) begin
                            n_status = ST_MISSING;
                        end else if (i_sts.same_key) begin
                            n_status = ST_SAME;
                        end else if (i_sts.hit_nk) begin
                            n_status = ST_DUP;
                        end else begin
                            o_cmd.update = 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (!i_sts.hit_k) begin
                            n_status = ST_MISSING;
                        end else begin
                            o_cmd.fetch  = 1'b1;
                            n_give_found = 1'b1;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.walk_done) begin
                    o_cmd.dec_fill = 1'b1;
                    n_status       = ST_OK;
                    n_state        = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_status     <= ST_OK;
            r_give_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_status     <= n_status;
            r_give_found <= n_give_found;
        end
    end

endmodule

### hdl/ket_dpath.sv
// ----------------------------------------------------------------------------
// ket_dpath
// Entry memories, fill count, limit register, scan/shift walker and
// result register.
// ----------------------------------------------------------------------------
`include "keyed_entry_table_macros.svh"

module ket_dpath
    import ket_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [LIMIT_W-1:0]        i_cfg_data,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [KEY_W-1:0]   i_key,
    input  logic signed [KEY_W-1:0]   i_new_key,
    input  logic [VAL_W-1:0]          i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STS_W-1:0]          o_status,
    output logic signed [KEY_W-1:0]   o_found_key,
    output logic [VAL_W-1:0]          o_found_value,
    output logic [COUNT_W-1:0]        o_entry_count,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts
);

    logic [KEY_W-1:0]   r_mem_key [CAPACITY];
    logic [VAL_W-1:0]   r_mem_val [CAPACITY];

    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_fill;
    t_opcode            r_op;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_new_key;
    logic [VAL_W-1:0]   r_value;

    logic [CNT_W-1:0]   r_ptr;
    logic               r_pipe_vld;
    logic [IDX_W-1:0]   r_pipe_addr;
    logic               r_hit_k;
    logic               r_hit_nk;
    logic [IDX_W-1:0]   r_slot;

    logic [KEY_W-1:0]   r_rd_key;
    logic [VAL_W-1:0]   r_rd_val;

    logic               r_out_valid;
    logic [STS_W-1:0]   r_status;
    logic [KEY_W-1:0]   r_found_key;
    logic [VAL_W-1:0]   r_found_value;
    logic [CNT_W-1:0]   r_count;

    logic               full;
    logic               walk_go;
    logic               out_free;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [VAL_W-1:0]   wr_val;

    assign full = (t_cmp'(r_fill) >= t_cmp'(r_limit)) ||
                  (t_cmp'(r_fill) >= t_cmp'(CAPACITY));
    assign walk_go  = (i_cmd.scan || i_cmd.shift) && (r_ptr < r_fill);
    assign out_free = !r_out_valid || i_out_ready;

    assign rd_en   = walk_go || i_cmd.fetch;
    assign rd_addr = i_cmd.fetch ? r_slot : r_ptr[IDX_W-1:0];

    // one write port: append, update in place, or compaction move
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_key  = r_new_key;
        wr_val  = r_value;
        if (i_cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[IDX_W-1:0];
            wr_key  = r_key;
        end else if (i_cmd.update) begin
            wr_en   = 1'b1;
        end else if (i_cmd.shift && r_pipe_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_pipe_addr - IDX_W'(1);
            wr_key  = r_rd_key;
            wr_val  = r_rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_key[wr_addr] <= wr_key;
            r_mem_val[wr_addr] <= wr_val;
        end
        if (rd_en) begin
            r_rd_key <= r_mem_key[rd_addr];
            r_rd_val <= r_mem_val[rd_addr];
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_opcode'(i_opcode);
            r_key     <= i_key;
            r_new_key <= i_new_key;
            r_value   <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(LIMIT_RESET);
            r_fill  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clr_fill) begin
                r_fill <= '0;
            end else if (i_cmd.append) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.dec_fill) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

    // walker: scan compares one entry per cycle, shift moves one entry down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_pipe_vld <= 1'b0;
            r_hit_k    <= 1'b0;
            r_hit_nk   <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_ptr      <= '0;
            r_pipe_vld <= 1'b0;
            r_hit_k    <= 1'b0;
            r_hit_nk   <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_ptr      <= CNT_W'(r_slot) + CNT_W'(1);
            r_pipe_vld <= 1'b0;
        end else if (i_cmd.scan || i_cmd.shift) begin
            r_pipe_vld <= walk_go;
            if (walk_go) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (i_cmd.scan && r_pipe_vld) begin
                if (!r_hit_k && (r_rd_key == r_key)) begin
                    r_hit_k <= 1'b1;
                end
                if (r_rd_key == r_new_key) begin
                    r_hit_nk <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_go) begin
            r_pipe_addr <= r_ptr[IDX_W-1:0];
        end
        // keep the first match only
        if (i_cmd.scan && r_pipe_vld && !r_hit_k && (r_rd_key == r_key)) begin
            r_slot <= r_pipe_addr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_status      <= i_cmd.status;
            r_found_key   <= i_cmd.give_found ? r_rd_key : '0;
            r_found_value <= i_cmd.give_found ? r_rd_val : '0;
            r_count       <= r_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_key   = r_found_key;
    assign o_found_value = r_found_value;
    assign o_entry_count = COUNT_W'(r_count);

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.full      = full;
        o_sts.hit_k     = r_hit_k;
        o_sts.hit_nk    = r_hit_nk;
        o_sts.same_key  = (r_key == r_new_key);
        o_sts.walk_done = !(r_ptr < r_fill) && !r_pipe_vld;
        o_sts.out_free  = out_free;
    end

    `KET_ASSERT_ALWAYS(a_fill_cap, i_clk, i_rst_n, r_fill <= CNT_W'(CAPACITY), "fill above capacity")
    `KET_ASSERT_IMPL(a_append_room, i_clk, i_rst_n, i_cmd.append, !full, "append into full table")
    `KET_ASSERT_IMPL(a_result_free, i_clk, i_rst_n, i_cmd.result, out_free, "result overwrites pending")
    `KET_ASSERT_IMPL(a_pipe_range, i_clk, i_rst_n, r_pipe_vld, CNT_W'(r_pipe_addr) < r_fill, "walk past fill")

endmodule

### hdl/keyed_entry_table.sv
// ----------------------------------------------------------------------------
// keyed_entry_table
// Key/value table kept packed in insertion order, searched linearly.
// Add, delete (with compaction), update, get and clear requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_opcode i_key i_new_key i_value
//  result    out        o_out_valid / i_out_ready  o_status o_found_key
//                                                  o_found_value o_entry_count
//  config    in         i_cfg_we                   i_cfg_data (capacity_limit)
//
//  One request at a time. Clear, unknown opcodes and add to a full table go from
//  decode straight to the result; other requests first scan the entries held
//  through the single read port of the entry memories. Delete then runs a compaction
//  walk on the same read port, moving each entry above the deleted slot down by one.
//  Synchronous active-low reset empties the table and sets the limit to 64.
//  A stalled result blocks the next result but not the next acceptance.
// ----------------------------------------------------------------------------
module keyed_entry_table
    import ket_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [LIMIT_W-1:0]        i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [KEY_W-1:0]   i_key,
    input  logic signed [KEY_W-1:0]   i_new_key,
    input  logic [VAL_W-1:0]          i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STS_W-1:0]          o_status,
    output logic signed [KEY_W-1:0]   o_found_key,
    output logic [VAL_W-1:0]          o_found_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    ket_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ket_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_new_key     (i_new_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule
